// File: design/ordered_value_list_defines.svh
// Assertion macros for the ordered value list
`ifndef ORDERED_VALUE_LIST_DEFINES_SVH
`define ORDERED_VALUE_LIST_DEFINES_SVH

`ifndef SYNTHESIS

`define OVL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ordered_value_list: assertion failed");

`define OVL_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("ordered_value_list: forbidden condition seen");

`else

`define OVL_ASSERT(lbl, clk, rst_n, prop)

`define OVL_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// File: design/ovl_pkg.sv
package ovl_pkg;

    localparam int ACTION_W    = 3;
    localparam int VALUE_W     = 32;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD      = 3'd0,
        ACT_REMOVE   = 3'd1,
        ACT_CONTAINS = 3'd2,
        ACT_CLEAR    = 3'd3,
        ACT_READ     = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_APPLY,
        ST_READ
    } ovl_state_t;

    typedef struct packed {
        logic load;
        logic compare;
        logic apply;
        logic read_step;
    } ovl_cmd_t;

    typedef struct packed {
        logic is_read;
        logic cnt_zero;
        logic rd_last;
    } ovl_status_t;

endpackage

// File: design/ovl_ctrl.sv
module ovl_ctrl
    import ovl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  ovl_status_t status,
    output ovl_cmd_t    cmd
);

    ovl_state_t state_reg;
    ovl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE:
            begin
                cmd.compare = 1'b1;
                state_next  = ST_APPLY;
            end
            ST_APPLY:
            begin
                cmd.apply = 1'b1;
                if (status.is_read && !status.cnt_zero)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                cmd.read_step = 1'b1;
                if (status.rd_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/ovl_datapath.sv
`include "ordered_value_list_defines.svh"

module ovl_datapath
    import ovl_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  ovl_cmd_t                  cmd,
    output ovl_status_t               status,
    input  logic [ACTION_W-1:0]       action,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      strobe,
    output logic                      ok,
    output logic signed [VALUE_W-1:0] entry_value,
    output logic [COUNT_OUT_W-1:0]    count,
    output logic                      last
);

    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [VALUE_W-1:0]        entries_reg [DEPTH];
    action_t                   action_reg;
    logic [VALUE_W-1:0]        value_reg;
    logic [COUNT_W-1:0]        cnt_reg;
    logic [COUNT_W-1:0]        cnt_next;
    logic [IDX_W-1:0]          rd_idx_reg;
    logic [DEPTH-1:0]          match_reg;
    logic [DEPTH-1:0]          match_next;
    logic [DEPTH-1:0]          shift_en;
    logic                      any_match;
    logic                      add_we;
    logic                      rm_en;
    logic                      emit;
    logic                      ok_c;
    logic                      strobe_reg;
    logic                      ok_reg;
    logic [VALUE_W-1:0]        entry_value_reg;
    logic [COUNT_OUT_W-1:0]    count_reg;
    logic                      last_reg;

    assign status.is_read  = (action_reg == ACT_READ);
    assign status.cnt_zero = (cnt_reg == '0);
    assign status.rd_last  = (rd_idx_reg == '0);

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            match_next[i] = (entries_reg[i] == value_reg) && (COUNT_W'(i) < cnt_reg);
        end
    end

    assign any_match = |match_reg;

    // shift down every cell at or above the newest match
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            shift_en[i] = any_match && (((match_reg >> i) >> 1) == '0);
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        add_we   = 1'b0;
        rm_en    = 1'b0;
        emit     = 1'b1;
        ok_c     = 1'b0;
        case (action_reg)
            ACT_ADD:
            begin
                if (cnt_reg < COUNT_W'(DEPTH))
                begin
                    add_we   = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    ok_c     = 1'b1;
                end
            end
            ACT_REMOVE:
            begin
                if (any_match)
                begin
                    rm_en    = 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                    ok_c     = 1'b1;
                end
            end
            ACT_CONTAINS:
            begin
                ok_c = any_match;
            end
            ACT_CLEAR:
            begin
                cnt_next = '0;
                ok_c     = 1'b1;
            end
            ACT_READ:
            begin
                emit = (cnt_reg == '0);
            end
            default:
            begin
                ok_c = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action_t'(action);
            value_reg  <= value;
        end
        if (cmd.compare)
        begin
            match_reg <= match_next;
        end
        if (cmd.apply && add_we)
        begin
            entries_reg[cnt_reg[IDX_W-1:0]] <= value_reg;
        end
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            if (cmd.apply && rm_en && shift_en[i])
            begin
                entries_reg[i] <= entries_reg[i+1];
            end
        end
        if (cmd.apply)
        begin
            rd_idx_reg <= IDX_W'(cnt_reg - 1'b1);
        end
        else if (cmd.read_step)
        begin
            rd_idx_reg <= rd_idx_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            if (cmd.apply)
            begin
                cnt_reg <= cnt_next;
            end
            strobe_reg <= (cmd.apply && emit) || cmd.read_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            ok_reg          <= ok_c;
            entry_value_reg <= '0;
            count_reg       <= COUNT_OUT_W'(cnt_next);
            last_reg        <= 1'b1;
        end
        else if (cmd.read_step)
        begin
            ok_reg          <= 1'b1;
            entry_value_reg <= entries_reg[rd_idx_reg];
            count_reg       <= COUNT_OUT_W'(cnt_reg);
            last_reg        <= (rd_idx_reg == '0);
        end
    end

    assign strobe      = strobe_reg;
    assign ok          = ok_reg;
    assign entry_value = entry_value_reg;
    assign count       = count_reg;
    assign last        = last_reg;

    `OVL_NEVER(a_cnt_bound, clk, rst_n, cnt_reg > COUNT_W'(DEPTH))
    `OVL_ASSERT(a_cnt_hold, clk, rst_n, !cmd.apply |=> $stable(cnt_reg))
    `OVL_ASSERT(a_read_burst, clk, rst_n, (strobe_reg && !last_reg) |=> strobe_reg)

endmodule

// File: design/ordered_value_list.sv
// Channel   Handshake      Payload                          Direction
// command   start / busy   action, value                    in
// result    strobe         ok, entry_value, count, last     out
//
// Single-word actions: strobe rises after the latch, the parallel compare in every cell and
// the apply into the output register, in that order; busy drops with the strobe.
// Read out: one word when empty as above, else the first word comes from the first READ step after the apply,
// then one per cycle, newest first; busy drops in the cycle of the last word.
// Reset clears the count and the controller; cell contents are not cleared.
// The receiver takes every word in the cycle its strobe is high.
module ordered_value_list
    import ovl_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [ACTION_W-1:0]       action,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      strobe,
    output logic                      ok,
    output logic signed [VALUE_W-1:0] entry_value,
    output logic [COUNT_OUT_W-1:0]    count,
    output logic                      last
);

    ovl_cmd_t    cmd;
    ovl_status_t status;

    ovl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    ovl_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .action      (action),
        .value       (value),
        .strobe      (strobe),
        .ok          (ok),
        .entry_value (entry_value),
        .count       (count),
        .last        (last)
    );

endmodule
